### sv/pfh_pkg.sv
`default_nettype none

package pfh_pkg;

  localparam int PERIOD_BITS_DEFAULT = 16;

  localparam int CLOCK_BITS  = 24;
  localparam int THRESH_BITS = 11;
  localparam int FREQ_BITS   = 16;
  localparam int Q10_SHIFT   = 10;

  localparam int CFG_INDEX_BITS = 1;

  localparam logic [CLOCK_BITS-1:0]  SCALED_CLOCK_RESET = CLOCK_BITS'(1114636);
  localparam logic [THRESH_BITS-1:0] THRESHOLD_RESET    = THRESH_BITS'(1004);
  localparam logic [FREQ_BITS-1:0]   FREQ_MAX           = '1;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_SCALED_CLOCK = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] CFG_THRESHOLD    = CFG_INDEX_BITS'(1);

endpackage

`default_nettype wire

### sv/period_to_frequency_with_hysteresis_unit.sv
// Reciprocal frequency counter with change hysteresis.
// The input channel (in_valid, in_stall, period_ticks) carries one measured
// period per transaction. The output channel (out_valid, out_stall, freq_hz)
// carries one frequency per reported period. A zero period, or one that is
// too close to the last reported period, produces no output transaction.
// The frequency is scaled_clock divided by the period, truncated and
// saturated at 65535. The configuration channel (cfg_valid, cfg_ready,
// cfg_index, cfg_data) writes scaled_clock (index 0) or the Q10 change
// threshold (index 1) and is meant to be used while the block is idle.
// The first period goes straight to the radix-2 restoring divider; later
// periods first pass through the change test in S_MUL_NEW, S_CMP_NEW and,
// if needed, S_CMP_OLD, which share one multiplier and comparator. The
// S_OUT state then loads the output register once it is free. A zero
// period is dropped without leaving idle, and a suppressed period goes back
// to idle from S_CMP_OLD without entering the divider or S_OUT.
// in_stall stays high until the item is done. A finished result waits in the
// output register while the receiver stalls, and the next item may be
// accepted meanwhile; a second result then waits until the first is taken.
// Reset restores both registers to their defaults and clears the memory of
// the last reported period, so the first nonzero period is always reported.
`default_nettype none

module period_to_frequency_with_hysteresis_unit
  import pfh_pkg::*;
#(
  parameter int PERIOD_BITS = PERIOD_BITS_DEFAULT
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [PERIOD_BITS-1:0]    period_ticks,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [FREQ_BITS-1:0]           freq_hz,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CLOCK_BITS-1:0]     cfg_data
);

  localparam int PROD_W     = THRESH_BITS + PERIOD_BITS;
  localparam int PAD_W      = PROD_W - PERIOD_BITS - Q10_SHIFT;
  localparam int COUNT_BITS = $clog2(CLOCK_BITS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_NEW,
    S_CMP_NEW,
    S_CMP_OLD,
    S_DIV,
    S_OUT
  } state_t;

  state_t                  state;
  logic [CLOCK_BITS-1:0]   scaled_clock;
  logic [THRESH_BITS-1:0]  threshold;
  logic [PERIOD_BITS-1:0]  period;
  logic [PERIOD_BITS-1:0]  last_period;
  logic                    reported_once;
  logic [PROD_W-1:0]       prod;
  logic [PERIOD_BITS-1:0]  rem;
  logic [CLOCK_BITS-1:0]   numq;
  logic [COUNT_BITS-1:0]   count;

  logic [PERIOD_BITS-1:0]  mul_b;
  logic [PROD_W-1:0]       mul_out;
  logic [PERIOD_BITS-1:0]  cmp_a;
  logic [PROD_W-1:0]       cmp_lhs;
  logic                    cmp_less;
  logic [PERIOD_BITS:0]    rem_shift;
  logic [PERIOD_BITS:0]    rem_diff;
  logic                    fits;
  logic [PERIOD_BITS-1:0]  rem_next;
  logic [CLOCK_BITS-1:0]   numq_next;
  logic [FREQ_BITS-1:0]    freq_next;
  logic                    out_free;

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign out_free  = !out_valid || !out_stall;

  // One multiplier and one comparator serve both halves of the change test.
  assign mul_b    = (state == S_MUL_NEW) ? period : last_period;
  assign mul_out  = {{PERIOD_BITS{1'b0}}, threshold} * {{THRESH_BITS{1'b0}}, mul_b};
  assign cmp_a    = (state == S_CMP_NEW) ? last_period : period;
  assign cmp_lhs  = {{PAD_W{1'b0}}, cmp_a, {Q10_SHIFT{1'b0}}};
  assign cmp_less = cmp_lhs < prod;

  assign rem_shift = {rem, numq[CLOCK_BITS-1]};
  assign rem_diff  = rem_shift - {1'b0, period};
  assign fits      = rem_shift >= {1'b0, period};
  assign rem_next  = fits ? rem_diff[PERIOD_BITS-1:0] : rem_shift[PERIOD_BITS-1:0];
  assign numq_next = {numq[CLOCK_BITS-2:0], fits};

  assign freq_next = (|numq[CLOCK_BITS-1:FREQ_BITS]) ? FREQ_MAX : numq[FREQ_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      scaled_clock  <= SCALED_CLOCK_RESET;
      threshold     <= THRESHOLD_RESET;
      last_period   <= '0;
      reported_once <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_SCALED_CLOCK: scaled_clock <= cfg_data;
          CFG_THRESHOLD:    threshold    <= cfg_data[THRESH_BITS-1:0];
          default:          ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            period <= period_ticks;
            rem    <= '0;
            numq   <= scaled_clock;
            count  <= '0;
            if (period_ticks == '0) begin
              state <= S_IDLE;
            end else if (!reported_once) begin
              state <= S_DIV;
            end else begin
              state <= S_MUL_NEW;
            end
          end
        end
        S_MUL_NEW: begin
          prod  <= mul_out;
          state <= S_CMP_NEW;
        end
        S_CMP_NEW: begin
          prod <= mul_out;
          if (cmp_less) begin
            state <= S_DIV;
          end else begin
            state <= S_CMP_OLD;
          end
        end
        S_CMP_OLD: begin
          if (cmp_less) begin
            state <= S_DIV;
          end else begin
            state <= S_IDLE;
          end
        end
        S_DIV: begin
          rem   <= rem_next;
          numq  <= numq_next;
          count <= count + COUNT_BITS'(1);
          if (count == COUNT_BITS'(CLOCK_BITS - 1)) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            freq_hz       <= freq_next;
            out_valid     <= 1'b1;
            last_period   <= period;
            reported_once <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_zero_ignored: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && period_ticks == '0) |=> (!in_stall && !$rose(out_valid)))
    else $error("zero period was not ignored");

  a_first_reported: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && period_ticks != '0 && !reported_once) |=> (state == S_DIV))
    else $error("first period did not go straight to the divider");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (rem < period))
    else $error("divider remainder out of range");

  a_result_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && out_free) |=> (out_valid && reported_once && last_period == period))
    else $error("result load did not update state");
`endif

endmodule

`default_nettype wire
